FILE: hdl/cst_pkg.sv
// Package for the connection state table: operation and status codes, entry layout.
// No dependencies.
package cst_pkg;
	typedef enum logic [1:0] {
		OP_SET = 2'd0,
		OP_GET = 2'd1,
		OP_DEL = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	localparam int KEY_W   = 96;
	localparam int STATE_W = 4;

	typedef struct packed {
		logic [31:0] src_addr;
		logic [15:0] src_port;
		logic [31:0] dst_addr;
		logic [15:0] dst_port;
	} key_t;

	typedef struct packed {
		op_t                  op;
		key_t                 key;
		logic [STATE_W-1:0]   new_state;
		logic [31:0]          sum;
	} req_t;
endpackage

FILE: hdl/cst_front.sv
// Front part: holds captured requests in a two-entry queue; the key sum is computed at the top level.
// Depends on cst_pkg.
module cst_front import cst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t push_req,
	input  logic pop,
	output logic empty,
	output logic full,
	output req_t head
);
	req_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= push_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

FILE: hdl/cst_back.sv
// Back part: reads one bucket, compares all ways, writes back, and emits the result.
// Depends on cst_pkg. After reset it first clears the valid marks of all buckets.
module cst_back import cst_pkg::*; #(
	parameter int NUM_BUCKETS = 256,
	parameter int WAYS        = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  req_t                req,
	output logic                req_pop,
	output logic                idle,
	output logic                done,
	output logic [STATE_W-1:0]  conn_state,
	output logic [1:0]          status
);
	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int EW = KEY_W + STATE_W;

	typedef enum logic [2:0] {
		S_CLR  = 3'b001,
		S_IDLE = 3'b010,
		S_EXEC = 3'b100
	} fsm_t;

	fsm_t state_q;
	logic [BW-1:0] clr_q;
	logic [BW-1:0] bucket;
	logic [BW-1:0] bucket_s1;
	req_t req_s1;

	logic [EW-1:0]   ent_mem [WAYS][NUM_BUCKETS];
	logic            vld_mem [WAYS][NUM_BUCKETS];
	logic [EW-1:0]   ent_rd_s1 [WAYS];
	logic [WAYS-1:0] vld_rd_s1;

	// bucket index: wrapping sum modulo bucket count
	assign bucket = BW'(req.sum % 32'(NUM_BUCKETS));

	assign req_pop = (state_q == S_IDLE) && req_valid;
	assign idle    = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (req_pop) begin
			req_s1    <= req;
			bucket_s1 <= bucket;
		end
	end

	logic [WAYS-1:0] hit, free;
	logic            any_hit, any_free;
	logic [$clog2(WAYS+1)-1:0] hit_w, free_w;
	logic [STATE_W-1:0] hit_state;

	always_comb begin
		hit       = '0;
		free      = '0;
		any_hit   = 1'b0;
		any_free  = 1'b0;
		hit_w     = '0;
		free_w    = '0;
		hit_state = '0;
		for (int w = 0; w < WAYS; w++) begin
			hit[w]  = vld_rd_s1[w] && (ent_rd_s1[w][EW-1:STATE_W] == req_s1.key);
			free[w] = !vld_rd_s1[w];
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (hit[w]) begin
				any_hit   = 1'b1;
				hit_w     = ($clog2(WAYS+1))'(w);
				hit_state = ent_rd_s1[w][STATE_W-1:0];
			end
			if (free[w]) begin
				any_free = 1'b1;
				free_w   = ($clog2(WAYS+1))'(w);
			end
		end
	end

	for (genvar w = 0; w < WAYS; w++) begin : g_way
		logic ent_we, vld_we, vld_d;
		logic [BW-1:0] waddr;
		always_comb begin
			ent_we = 1'b0;
			vld_we = 1'b0;
			vld_d  = 1'b0;
			waddr  = bucket_s1;
			if (state_q == S_CLR) begin
				vld_we = 1'b1;
				waddr  = clr_q;
			end else if (state_q == S_EXEC) begin
				case (req_s1.op)
					OP_SET: begin
						if (any_hit) begin
							ent_we = (hit_w == ($clog2(WAYS+1))'(w));
						end else if (any_free && free_w == ($clog2(WAYS+1))'(w)) begin
							ent_we = 1'b1;
							vld_we = 1'b1;
							vld_d  = 1'b1;
						end
					end
					OP_DEL: vld_we = any_hit && (hit_w == ($clog2(WAYS+1))'(w));
					default: ;
				endcase
			end
		end
		always_ff @(posedge clk) begin
			if (ent_we)
				ent_mem[w][waddr] <= {req_s1.key, req_s1.new_state};
			if (vld_we)
				vld_mem[w][waddr] <= vld_d;
			if (req_pop) begin
				ent_rd_s1[w] <= ent_mem[w][bucket];
				vld_rd_s1[w] <= vld_mem[w][bucket];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_q      <= '0;
			done       <= 1'b0;
			conn_state <= '0;
			status     <= ST_DONE;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BW'(NUM_BUCKETS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q    <= S_IDLE;
					done       <= 1'b1;
					conn_state <= '0;
					status     <= ST_DONE;
					case (req_s1.op)
						OP_SET: if (!any_hit && !any_free) status <= ST_FULL;
						OP_GET: begin
							if (any_hit) conn_state <= hit_state;
							else         status     <= ST_NOT_FOUND;
						end
						OP_DEL: if (!any_hit) status <= ST_NOT_FOUND;
						default: ;
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: hdl/connection_state_table.sv
// Top level of the connection state table: front request queue and back bucket engine.
// Depends on cst_pkg, cst_front, cst_back.
//
// channel   direction  handshake              payload
// request   in         start & !busy          operation, src/dst addr and port, new_state
// result    out        done (one cycle)       conn_state, status
//
// In the back engine each request has a bucket read, then compare and
// write-back. The front queue holds two requests, so start is taken while the
// engine works. After reset a clearing pass over all NUM_BUCKETS buckets clears
// the valid marks; busy is high then. Results are never stalled.
module connection_state_table import cst_pkg::*; #(
	parameter int NUM_BUCKETS = 256,
	parameter int WAYS        = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [31:0] src_addr,
	input  logic [15:0] src_port,
	input  logic [31:0] dst_addr,
	input  logic [15:0] dst_port,
	input  logic [3:0]  new_state,
	output logic        done,
	output logic [3:0]  conn_state,
	output logic [1:0]  status
);
	logic q_full, q_empty, pop, back_idle;
	req_t push_req, head;
	logic clr_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_done_q <= 1'b0;
		else if (back_idle) clr_done_q <= 1'b1;
	end

	assign busy = q_full || !clr_done_q;

	always_comb begin
		push_req.op        = op_t'(operation);
		push_req.key       = {src_addr, src_port, dst_addr, dst_port};
		push_req.new_state = new_state;
		push_req.sum       = src_addr + 32'(src_port) + dst_addr + 32'(dst_port);
	end

	cst_front u_front (
		.clk(clk), .arst_n(arst_n),
		.push(start && !busy), .push_req(push_req),
		.pop(pop), .empty(q_empty), .full(q_full), .head(head)
	);

	cst_back #(.NUM_BUCKETS(NUM_BUCKETS), .WAYS(WAYS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.req_valid(!q_empty), .req(head), .req_pop(pop), .idle(back_idle),
		.done(done), .conn_state(conn_state), .status(status)
	);

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty) else $error("pop from empty queue");
	// dispatch edge, then the compare cycle, then the result cycle
	a_done_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> ##2 done) else $error("result missing after dispatch");
	a_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status != 2'd3)) else $error("bad status");
	a_state_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_DONE) |-> (conn_state == 4'd0))
		else $error("state not closed on miss");
endmodule

FILE: bench/connection_state_table_tb.sv
// Self-checking bench for connection_state_table: keeps a shadow copy of every
// bucket, predicts each result and checks it. Depends on cst_pkg and the RTL.
`timescale 1ns / 100ps

module connection_state_table_tb;
	import cst_pkg::*;

	localparam int NB = 256;
	localparam int NW = 4;
	localparam int WATCHDOG = 20000;

	typedef struct {
		logic [3:0] conn_state;
		logic [1:0] status;
	} outcome_t;

	class conn_scoreboard;
		bit         valid [NB][NW];
		key_t       key   [NB][NW];
		logic [3:0] cst   [NB][NW];
		outcome_t   pending [$];
		int         errors;

		function new();
			errors = 0;
			foreach (valid[b, w]) valid[b][w] = 0;
		endfunction

		function void note_request(op_t op, key_t k, logic [3:0] ns);
			logic [31:0] sum;
			int b, hit, freew;
			outcome_t o;
			sum = k.src_addr + 32'(k.src_port) + k.dst_addr + 32'(k.dst_port);
			b = sum % NB;
			hit = -1;
			freew = -1;
			for (int w = NW - 1; w >= 0; w--) begin
				if (valid[b][w] && key[b][w] == k) hit = w;
				if (!valid[b][w]) freew = w;
			end
			o.conn_state = 4'd0;
			o.status = ST_DONE;
			case (op)
				OP_SET: begin
					if (hit >= 0) cst[b][hit] = ns;
					else if (freew >= 0) begin
						valid[b][freew] = 1;
						key[b][freew] = k;
						cst[b][freew] = ns;
					end else o.status = ST_FULL;
				end
				OP_GET: begin
					if (hit >= 0) o.conn_state = cst[b][hit];
					else o.status = ST_NOT_FOUND;
				end
				OP_DEL: begin
					if (hit >= 0) valid[b][hit] = 0;
					else o.status = ST_NOT_FOUND;
				end
				default: ;
			endcase
			pending.push_back(o);
		endfunction

		function void check_result(logic [3:0] cs, logic [1:0] st);
			outcome_t o;
			if (pending.size() == 0) begin
				$error("result with no request pending: conn_state %0d status %0d", cs, st);
				errors++;
				return;
			end
			o = pending.pop_front();
			if (cs !== o.conn_state) begin
				$error("conn_state: expected %0d, got %0d", o.conn_state, cs);
				errors++;
			end
			if (st !== o.status) begin
				$error("status: expected %0d, got %0d", o.status, st);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0, start = 0;
	logic [1:0] operation = 0;
	logic [31:0] src_addr = 0, dst_addr = 0;
	logic [15:0] src_port = 0, dst_port = 0;
	logic [3:0] new_state = 0;
	logic busy, done;
	logic [3:0] conn_state;
	logic [1:0] status;

	conn_scoreboard sb = new();
	int idle_cycles = 0;
	key_t pool [16];

	connection_state_table #(.NUM_BUCKETS(NB), .WAYS(NW)) uut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk) begin
		if (done) sb.check_result(conn_state, status);
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Drive one request and hold it until accepted.
	task automatic send_request(op_t op, key_t k, logic [3:0] ns, bit allow_gap);
		if (allow_gap && $urandom_range(0, 3) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		start <= 1;
		operation <= op;
		{src_addr, src_port, dst_addr, dst_port} <= k;
		new_state <= ns;
		do @(posedge clk); while (busy);
		sb.note_request(op, k, ns);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic key_t random_key();
		return {$urandom, 16'($urandom), $urandom, 16'($urandom)};
	endfunction

	// Build a key in bucket b by fixing dst_port to cancel the rest of the sum.
	function automatic key_t key_in_bucket(int b);
		key_t k;
		logic [31:0] s;
		k = random_key();
		s = k.src_addr + 32'(k.src_port) + k.dst_addr + 32'(k.dst_port);
		k.dst_port = k.dst_port + 16'((b - s[7:0]) & 8'hff);
		return k;
	endfunction

	initial begin
		key_t k, kmax, full [5];
		op_t op;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: extremes, each operation, full bucket, absent keys, NOP
		kmax = '1;
		send_request(OP_GET, kmax, 4'd0, 0);
		send_request(OP_DEL, kmax, 4'd0, 0);
		send_request(OP_SET, kmax, 4'd15, 0);
		send_request(OP_GET, kmax, 4'd0, 0);
		send_request(OP_SET, '0, 4'd10, 0);
		send_request(OP_SET, '0, 4'd3, 0);
		send_request(OP_GET, '0, 4'd0, 0);
		for (int i = 0; i < 5; i++) begin
			full[i] = key_in_bucket(77);
			send_request(OP_SET, full[i], 4'(i + 1), 0);
		end
		send_request(OP_GET, full[4], 4'd0, 0);
		send_request(OP_DEL, full[0], 4'd0, 0);
		send_request(OP_DEL, full[0], 4'd0, 0);
		send_request(OP_SET, full[4], 4'd9, 0);
		send_request(OP_GET, full[4], 4'd0, 0);
		send_request(OP_NOP, kmax, 4'd7, 0);
		send_request(OP_DEL, kmax, 4'd0, 0);
		send_request(OP_GET, kmax, 4'd0, 0);
		drain();

		// random: keys mostly from a small pool of sixteen, six of which crowd bucket 5
		for (int i = 0; i < 16; i++) pool[i] = key_in_bucket(i % 3 == 0 ? 5 : $urandom_range(0, 255));
		for (int n = 0; n < 1030; n++) begin
			if ($urandom_range(0, 9) < 8) k = pool[$urandom_range(0, 15)];
			else k = random_key();
			case ($urandom_range(0, 19))
				0: op = OP_NOP;
				1, 2, 3, 4, 5, 6, 7: op = OP_SET;
				8, 9, 10, 11, 12, 13: op = OP_GET;
				default: op = OP_DEL;
			endcase
			send_request(op, k, 4'($urandom), n < 900);
			if (n == 500) drain();
		end
		drain();
		repeat (20) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end
endmodule
